@@ sv/sta_pkg.sv @@
// Package for the session table: payload structs, entry layout, codes and sizes.
// Used by sta_ram's user session_table_with_aging; no dependencies.
`default_nettype none

package sta_pkg;

  localparam int MAX_SLOTS   = 32;
  localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_SLOTS_W = 6;

  localparam logic [CFG_SLOTS_W-1:0] SLOTS_RESET   = 6'd32;
  localparam logic [CFG_W-1:0]       TIMEOUT_RESET = 32'd30000;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 1'd1;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FIND  = 3'd1;
  localparam logic [2:0] OP_DROP  = 3'd2;
  localparam logic [2:0] OP_TOUCH = 3'd3;
  localparam logic [2:0] OP_REAP  = 3'd4;
  localparam logic [2:0] OP_LIST  = 3'd5;

  typedef enum logic [2:0] {
    STS_CREATED   = 3'd0,
    STS_HIT       = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_EXPIRED   = 3'd4,
    STS_LISTED    = 3'd5,
    STS_END       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT,
    S_MARK,
    S_EMIT,
    S_END
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [47:0] peer_key;
    logic [23:0] nonce;
    logic [63:0] now_ms;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  slot;
    logic [47:0] peer_out;
    logic [23:0] nonce_out;
    logic [63:0] connected_at;
    logic [63:0] seen_at;
    logic [5:0]  count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [47:0] peer;
    logic [23:0] nonce;
    logic [63:0] connected;
    logic [63:0] seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ sv/session_table_with_aging.sv @@
// Session table with timeout aging: sequencer, valid bits, config and output register.
// Depends on sta_pkg and sta_ram (entry store).
//
//   channel  signals                          width  direction
//   req      req_valid, req_stall, req        139    in
//   rsp      rsp_valid, rsp_stall, rsp        215    out
//   cfg      cfg_write, cfg_index, cfg_data   1+32   in
//
// Allocate, find, drop, touch: a scan with one pipelined entry-RAM read a slot.
// Reap: a mark pass and an emit pass over the RAM.
// List: one emit pass over the RAM; a stalled result holds the emit pass.
// Reset clears valid bits and counters and loads the config reset values; entries need no clearing.
// A new request transfers while the previous result still waits in the output register.
`default_nettype none

module session_table_with_aging (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire sta_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output sta_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_write,
  input  wire logic [sta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sta_pkg::CFG_W-1:0]       cfg_data
);

  import sta_pkg::*;

  state_t                 state, state_next;
  req_t                   cur;
  logic [CNT_W-1:0]       rd_idx;
  logic                   chk_valid;
  logic [SLOT_W-1:0]      chk_idx;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_idx;
  entry_t                 hit_entry;
  logic [MAX_SLOTS-1:0]   expire_mask;
  logic [CNT_W-1:0]       dropped;
  logic [MAX_SLOTS-1:0]   slot_valid, slot_valid_next;
  logic [CNT_W-1:0]       active_cnt, active_cnt_next;
  logic [CFG_SLOTS_W-1:0] slots_in_use;
  logic [CFG_W-1:0]       idle_limit;
  rsp_t                   rsp_next;

  logic                   accept;
  logic                   out_free;
  logic                   load;
  logic                   advance;
  logic                   scan_active;
  logic                   scan_done;
  logic                   rd_en;
  logic [SLOT_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 rd_entry;
  logic                   chk_match;
  logic                   chk_expire;
  logic [63:0]            age;
  logic [MAX_SLOTS-1:0]   emit_mask;
  logic                   emit_hit;
  logic                   is_reap;
  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;
  entry_t                 mem_wdata;
  entry_t                 new_entry;
  logic [CFG_SLOTS_W-1:0] limit;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;

  sta_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SLOTS)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rd_entry  = entry_t'(ram_rdata);
  assign is_reap   = (cur.operation == OP_REAP);

  always_comb begin
    age        = cur.now_ms - rd_entry.seen;
    chk_match  = chk_valid && slot_valid[chk_idx] && (rd_entry.peer == cur.peer_key);
    chk_expire = chk_valid && slot_valid[chk_idx] && (age > 64'(idle_limit));
    emit_mask  = is_reap ? expire_mask : slot_valid;
    emit_hit   = chk_valid && emit_mask[chk_idx];
    scan_active = (state == S_SCAN) || (state == S_MARK) || (state == S_EMIT);
    advance    = (state == S_EMIT) ? (!emit_hit || out_free) : 1'b1;
    rd_en      = scan_active && advance && (rd_idx < CNT_W'(MAX_SLOTS));
    rd_addr    = rd_idx[SLOT_W-1:0];
    scan_done  = advance && (rd_idx == CNT_W'(MAX_SLOTS));
  end

  always_comb begin
    limit = (slots_in_use < CFG_SLOTS_W'(MAX_SLOTS)) ? slots_in_use : CFG_SLOTS_W'(MAX_SLOTS);
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i] && (i < int'(limit))) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            OP_ALLOC, OP_FIND, OP_DROP, OP_TOUCH: state_next = S_SCAN;
            OP_REAP:                              state_next = S_MARK;
            OP_LIST:                              state_next = S_EMIT;
            default:                              state_next = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        if (chk_match || scan_done) state_next = S_RESULT;
      end
      S_MARK: begin
        if (scan_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (scan_done) state_next = S_END;
      end
      S_RESULT, S_END: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    load            = 1'b0;
    rsp_next        = '0;
    mem_we          = 1'b0;
    mem_waddr       = hit_idx;
    new_entry       = '{peer: cur.peer_key, nonce: cur.nonce,
                        connected: cur.now_ms, seen: cur.now_ms};
    mem_wdata       = hit_entry;
    mem_wdata.seen  = cur.now_ms;
    slot_valid_next = slot_valid;
    active_cnt_next = active_cnt;
    unique case (state)
      S_RESULT: begin
        rsp_next.last   = 1'b1;
        rsp_next.status = STS_NOT_FOUND;
        rsp_next.count  = 6'(active_cnt);
        if (out_free) begin
          load = 1'b1;
        end
        if (hit) begin
          rsp_next.slot         = 5'(hit_idx);
          rsp_next.peer_out     = hit_entry.peer;
          rsp_next.nonce_out    = hit_entry.nonce;
          rsp_next.connected_at = hit_entry.connected;
          rsp_next.seen_at      = hit_entry.seen;
        end
        unique case (cur.operation)
          OP_ALLOC: begin
            if (hit) begin
              rsp_next.status  = STS_HIT;
              rsp_next.seen_at = cur.now_ms;
              mem_we           = out_free;
            end else if (free_found) begin
              rsp_next.status       = STS_CREATED;
              rsp_next.slot         = 5'(free_idx);
              rsp_next.peer_out     = new_entry.peer;
              rsp_next.nonce_out    = new_entry.nonce;
              rsp_next.connected_at = new_entry.connected;
              rsp_next.seen_at      = new_entry.seen;
              rsp_next.count        = 6'(active_cnt + CNT_W'(1));
              mem_we                = out_free;
              mem_waddr             = free_idx;
              mem_wdata             = new_entry;
              if (out_free) begin
                slot_valid_next[free_idx] = 1'b1;
                active_cnt_next           = active_cnt + CNT_W'(1);
              end
            end else begin
              rsp_next.status = STS_FULL;
            end
          end
          OP_FIND: begin
            if (hit) rsp_next.status = STS_HIT;
          end
          OP_DROP: begin
            if (hit) begin
              rsp_next.status = STS_HIT;
              rsp_next.count  = 6'(active_cnt - CNT_W'(1));
              if (out_free) begin
                slot_valid_next[hit_idx] = 1'b0;
                active_cnt_next          = active_cnt - CNT_W'(1);
              end
            end
          end
          OP_TOUCH: begin
            if (hit) begin
              rsp_next.status  = STS_HIT;
              rsp_next.seen_at = cur.now_ms;
              mem_we           = out_free;
            end
          end
          default: rsp_next.status = STS_NOT_FOUND;
        endcase
      end
      S_EMIT: begin
        rsp_next.status       = is_reap ? STS_EXPIRED : STS_LISTED;
        rsp_next.slot         = 5'(chk_idx);
        rsp_next.peer_out     = rd_entry.peer;
        rsp_next.nonce_out    = rd_entry.nonce;
        rsp_next.connected_at = rd_entry.connected;
        rsp_next.seen_at      = rd_entry.seen;
        rsp_next.count        = is_reap ? 6'(active_cnt - dropped) : 6'(active_cnt);
        load                  = emit_hit && out_free;
      end
      S_END: begin
        rsp_next.status = STS_END;
        rsp_next.count  = is_reap ? 6'(dropped) : 6'(active_cnt);
        rsp_next.last   = 1'b1;
        load            = out_free;
        if (out_free && is_reap) begin
          slot_valid_next = slot_valid & ~expire_mask;
          active_cnt_next = active_cnt - dropped;
        end
      end
      S_IDLE, S_SCAN, S_MARK: begin
        load = 1'b0;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_idx       <= '0;
      chk_valid    <= 1'b0;
      hit          <= 1'b0;
      expire_mask  <= '0;
      dropped      <= '0;
      slot_valid   <= '0;
      active_cnt   <= '0;
      slots_in_use <= SLOTS_RESET;
      idle_limit   <= TIMEOUT_RESET;
      rsp_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      active_cnt <= active_cnt_next;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[CFG_SLOTS_W-1:0];
          CFG_IDLE_LIMIT:   idle_limit   <= cfg_data;
          default:          idle_limit   <= idle_limit;
        endcase
      end

      if (accept) begin
        rd_idx      <= '0;
        chk_valid   <= 1'b0;
        hit         <= 1'b0;
        expire_mask <= '0;
        dropped     <= '0;
      end else if (scan_active && advance) begin
        if (rd_en) begin
          chk_valid <= 1'b1;
          rd_idx    <= rd_idx + CNT_W'(1);
        end else begin
          chk_valid <= 1'b0;
        end
        if (state == S_MARK && scan_done) begin
          rd_idx <= '0;
        end
      end

      if (state == S_SCAN && chk_match) begin
        hit <= 1'b1;
      end
      if (state == S_MARK && chk_expire) begin
        expire_mask[chk_idx] <= 1'b1;
        dropped              <= dropped + CNT_W'(1);
      end

      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (rd_en) begin
      chk_idx <= rd_addr;
    end
    if (state == S_SCAN && chk_match) begin
      hit_idx   <= chk_idx;
      hit_entry <= rd_entry;
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    int'(active_cnt) == $countones(slot_valid))
    else $error("active count out of step with valid bits");

  a_write_only_at_result: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_RESULT) && !rd_en)
    else $error("entry write overlaps a scan");

  a_dropped_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT || state == S_END) |-> (dropped <= active_cnt))
    else $error("reap drop count exceeds active sessions");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("transfer accepted without starting work");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ sv/sta_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
`default_nettype none

module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
